/* design/sst_pkg.sv */
package sst_pkg;
    localparam int MaxWidth  = 64;
    localparam int MaxHeight = 64;
    localparam int XW = $clog2(MaxWidth);
    localparam int YW = $clog2(MaxHeight);
    localparam int AW = XW + YW;
    localparam int Depth = MaxWidth * MaxHeight;
    localparam int PW = 8;
    localparam int IW = 11;
    localparam int RW = 7;
    localparam logic [PW-1:0] StartLimit = 8'd9;

    localparam logic [0:0] OpLoad = 1'b0;
    localparam logic [0:0] OpNext = 1'b1;

    localparam logic [0:0] RegWidth  = 1'b0;
    localparam logic [0:0] RegHeight = 1'b1;

    // neighbour order: up, right, down, left, ur, lr, ll, ul
    function automatic logic signed [1:0] nb_dx(input logic [2:0] k);
        case (k)
            3'd0: nb_dx = 2'sd0;
            3'd1: nb_dx = 2'sd1;
            3'd2: nb_dx = 2'sd0;
            3'd3: nb_dx = -2'sd1;
            3'd4: nb_dx = 2'sd1;
            3'd5: nb_dx = 2'sd1;
            3'd6: nb_dx = -2'sd1;
            default: nb_dx = -2'sd1;
        endcase
    endfunction

    function automatic logic signed [1:0] nb_dy(input logic [2:0] k);
        case (k)
            3'd0: nb_dy = -2'sd1;
            3'd1: nb_dy = 2'sd0;
            3'd2: nb_dy = 2'sd1;
            3'd3: nb_dy = 2'sd0;
            3'd4: nb_dy = -2'sd1;
            3'd5: nb_dy = 2'sd1;
            3'd6: nb_dy = 2'sd1;
            default: nb_dy = -2'sd1;
        endcase
    endfunction
endpackage

/* design/skeleton_segment_tracer_unit.sv */
// Channel | Valid   | Stall   | Payload
// input   | i_valid | o_stall | i_operation, i_pixel_x, i_pixel_y, i_pixel_value
// output  | o_valid | i_stall | o_point_x, o_point_y, o_segment_start, o_segment_index,
//         |         |         | o_done_res
// A load writes the pixel value into the store. A next request inside a segment
// probes up to eight neighbours, one store read each, and falls back to a start
// search when none of them is set.
// A start search sweeps width x height entries through the single read port;
// each lonely start is cleared, its eight neighbours probed, and the sweep rerun.
// Reset is synchronous; the store holds no reset. Input stalls while a request
// runs or its result waits at the output register.
module skeleton_segment_tracer_unit
    import sst_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [0:0]    i_cfg_index,
    input  logic [RW-1:0] i_cfg_data,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [0:0]    i_operation,
    input  logic [XW-1:0] i_pixel_x,
    input  logic [YW-1:0] i_pixel_y,
    input  logic [PW-1:0] i_pixel_value,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [XW-1:0] o_point_x,
    output logic [YW-1:0] o_point_y,
    output logic          o_segment_start,
    output logic [IW-1:0] o_segment_index,
    output logic          o_done_res
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_NBRD  = 7'b0000010,   // issue neighbour read
        S_NBCK  = 7'b0000100,   // check neighbour data
        S_SCAN  = 7'b0001000,   // sweep store
        S_SCEND = 7'b0010000,   // last sweep data
        S_CLR   = 7'b0100000,   // clear start, probe its neighbours
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [RW-1:0] r_w, r_h;
    logic [XW-1:0] r_cx, n_cx;
    logic [YW-1:0] r_cy, n_cy;
    logic r_inseg, n_inseg;
    logic [IW-1:0] r_seg, n_seg;
    logic [2:0] r_k, n_k;
    logic r_starting, n_starting;   // probing neighbours of a fresh start
    logic [XW-1:0] r_sx, n_sx, r_px, n_px;
    logic [YW-1:0] r_sy, n_sy, r_py, n_py;
    logic r_pvld, n_pvld;
    logic [PW-1:0] r_best, n_best;
    logic [XW-1:0] r_bx, n_bx, r_nx, n_nx;
    logic [YW-1:0] r_by, n_by, r_ny, n_ny;
    logic r_nok, n_nok;
    logic r_ov, n_ov;
    logic [XW-1:0] r_ox, n_ox;
    logic [YW-1:0] r_oy, n_oy;
    logic r_ost, n_ost, r_odn, n_odn;
    logic [IW-1:0] r_oix, n_oix;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [PW-1:0] wdata, rdata;

    sst_ram #(.Width(PW), .Depth(Depth)) u_store (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    function automatic logic [RW-1:0] clampv(input logic [RW-1:0] v, input int m);
        if (v == '0) return RW'(1);
        if (int'(v) > m) return RW'(m);
        return v;
    endfunction

    // neighbour k of (r_cx, r_cy)
    logic signed [XW+1:0] kx;
    logic signed [YW+1:0] ky;
    logic kin;
    always_comb begin
        kx = $signed({2'b00, r_cx}) + (XW+2)'(nb_dx(r_k));
        ky = $signed({2'b00, r_cy}) + (YW+2)'(nb_dy(r_k));
        kin = (kx >= 0) && (ky >= 0) && (kx < $signed({1'b0, r_w}))
              && (ky < $signed({1'b0, r_h}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= RW'(MaxWidth);
            r_h <= RW'(MaxHeight);
        end else if (i_cfg_we) begin
            if (i_cfg_index == RegWidth) r_w <= clampv(i_cfg_data, MaxWidth);
            else r_h <= clampv(i_cfg_data, MaxHeight);
        end
    end

    assign o_stall = (r_state != S_IDLE) || r_ov;

    always_comb begin
        n_state = r_state; n_cx = r_cx; n_cy = r_cy; n_inseg = r_inseg;
        n_seg = r_seg; n_k = r_k; n_starting = r_starting;
        n_sx = r_sx; n_sy = r_sy; n_px = r_px; n_py = r_py;
        n_pvld = 1'b0;
        n_best = r_best; n_bx = r_bx; n_by = r_by;
        n_nx = r_nx; n_ny = r_ny; n_nok = 1'b0;
        n_ov = r_ov; n_ox = r_ox; n_oy = r_oy; n_ost = r_ost;
        n_odn = r_odn; n_oix = r_oix;
        we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
        if (r_ov && !i_stall) n_ov = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && !o_stall) begin
                    if (i_operation == OpLoad) begin
                        we = 1'b1; waddr = {i_pixel_y, i_pixel_x}; wdata = i_pixel_value;
                    end else if (r_inseg) begin
                        n_k = '0; n_starting = 1'b0; n_state = S_NBRD;
                    end else begin
                        n_sx = '0; n_sy = '0; n_best = StartLimit; n_state = S_SCAN;
                    end
                end
            end
            S_NBRD: begin
                raddr = {ky[YW-1:0], kx[XW-1:0]};
                n_nok = kin;
                n_nx = kx[XW-1:0]; n_ny = ky[YW-1:0];
                n_state = S_NBCK;
            end
            S_NBCK: begin
                if (r_nok && rdata != '0) begin
                    n_ov = 1'b1; n_odn = 1'b0; n_state = S_OUT;
                    if (r_starting) begin
                        n_seg = r_seg + IW'(1); n_inseg = 1'b1;
                        n_ox = r_cx; n_oy = r_cy; n_ost = 1'b1; n_oix = r_seg + IW'(1);
                    end else begin
                        we = 1'b1; waddr = {r_ny, r_nx}; wdata = '0;
                        n_cx = r_nx; n_cy = r_ny;
                        n_ox = r_nx; n_oy = r_ny; n_ost = 1'b0; n_oix = r_seg;
                    end
                end else if (r_k != 3'd7) begin
                    n_k = r_k + 3'd1; n_state = S_NBRD;
                end else begin
                    n_inseg = 1'b0; n_sx = '0; n_sy = '0; n_best = StartLimit;
                    n_state = S_SCAN;
                end
            end
            S_SCAN, S_SCEND: begin
                if (r_pvld && rdata != '0 && rdata < r_best) begin
                    n_best = rdata; n_bx = r_px; n_by = r_py;
                end
                if (r_state == S_SCAN) begin
                    raddr = {r_sy, r_sx};
                    n_pvld = 1'b1; n_px = r_sx; n_py = r_sy;
                    if ({1'b0, r_sx} == r_w - RW'(1)) begin
                        n_sx = '0;
                        if ({1'b0, r_sy} == r_h - RW'(1)) n_state = S_SCEND;
                        else n_sy = r_sy + YW'(1);
                    end else n_sx = r_sx + XW'(1);
                end else begin
                    n_state = S_CLR;
                end
            end
            S_CLR: begin
                if (r_best == StartLimit) begin
                    n_ov = 1'b1; n_ox = '0; n_oy = '0; n_ost = 1'b0; n_oix = '0;
                    n_odn = 1'b1; n_state = S_OUT;
                end else begin
                    we = 1'b1; waddr = {r_by, r_bx}; wdata = '0;
                    n_cx = r_bx; n_cy = r_by; n_k = '0; n_starting = 1'b1;
                    n_state = S_NBRD;
                end
            end
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_cx <= '0; r_cy <= '0; r_inseg <= 1'b0;
            r_seg <= '1; r_ov <= 1'b0; r_pvld <= 1'b0; r_nok <= 1'b0;
        end else begin
            r_state <= n_state; r_cx <= n_cx; r_cy <= n_cy; r_inseg <= n_inseg;
            r_seg <= n_seg; r_ov <= n_ov; r_pvld <= n_pvld; r_nok <= n_nok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k <= n_k; r_starting <= n_starting; r_sx <= n_sx; r_sy <= n_sy;
        r_px <= n_px; r_py <= n_py; r_best <= n_best; r_bx <= n_bx; r_by <= n_by;
        r_nx <= n_nx; r_ny <= n_ny; r_ox <= n_ox; r_oy <= n_oy; r_ost <= n_ost;
        r_odn <= n_odn; r_oix <= n_oix;
    end

    assign o_valid = r_ov;
    assign o_point_x = r_ox;
    assign o_point_y = r_oy;
    assign o_segment_start = r_ost;
    assign o_segment_index = r_oix;
    assign o_done_res = r_odn;
endmodule

/* design/sst_ram.sv */
module sst_ram #(
    parameter int Width = 8,
    parameter int Depth = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* design/sst_checker.sv */
module sst_checker
    import sst_pkg::*;
(
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_stall,
    input logic          o_valid,
    input logic          i_stall,
    input logic [XW-1:0] o_point_x,
    input logic [YW-1:0] o_point_y,
    input logic          o_segment_start,
    input logic [IW-1:0] o_segment_index,
    input logic          o_done_res
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_segment_index))
        else $error("stalled result changed");
    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_done_res |-> !o_segment_start && o_point_x == '0 && o_point_y == '0)
        else $error("done result carries a point");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while result waits");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result after reset");
endmodule

bind skeleton_segment_tracer_unit sst_checker u_sst_checker (.*);
